[hdl/bbhs_pkg.sv]
// shared types, codes and the crc-8 helper for the bit-banged link master
package bbhs_pkg;

  // frame length of a receive transfer sequence
  localparam int unsigned RxFrameBytes = 7;

  // input kinds
  localparam logic [2:0] KIND_BEGIN_SEND = 3'd0;
  localparam logic [2:0] KIND_BEGIN_RECV = 3'd1;
  localparam logic [2:0] KIND_TICK       = 3'd2;
  localparam logic [2:0] KIND_SEND_BYTE  = 3'd3;
  localparam logic [2:0] KIND_RECV_BIT   = 3'd4;
  localparam logic [2:0] KIND_RELEASE    = 3'd5;

  // result status codes
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_HS    = 3'd1;
  localparam logic [2:0] ST_READY = 3'd2;
  localparam logic [2:0] ST_FAIL  = 3'd3;
  localparam logic [2:0] ST_GOOD  = 3'd4;
  localparam logic [2:0] ST_BAD   = 3'd5;
  localparam logic [2:0] ST_REJ   = 3'd6;

  // configuration register indexes
  localparam logic [2:0] REG_SEND_ACK_WINDOW    = 3'd0;
  localparam logic [2:0] REG_ACK_RUN_NEEDED     = 3'd1;
  localparam logic [2:0] REG_SEND_RELEASE_LIMIT = 3'd2;
  localparam logic [2:0] REG_RECV_HOLD_TICKS    = 3'd3;
  localparam logic [2:0] REG_RECV_RELEASE_LIMIT = 3'd4;
  localparam logic [2:0] REG_VERIFY_ECHO        = 3'd5;

  localparam int unsigned ApbAddrWidth = 5;

  // configuration values seen by the core
  typedef struct packed {
    logic [7:0] send_ack_window;
    logic [3:0] ack_run_needed;
    logic [5:0] send_release_limit;
    logic [7:0] recv_hold_ticks;
    logic [7:0] recv_release_limit;
    logic       verify_echo;
  } cfg_t;

  // result descriptor from the core to the output stage
  typedef struct packed {
    logic       multi;      // send byte: eight bit results from data
    logic [7:0] data;
    logic       mosi;
    logic [2:0] status;
    logic [7:0] rx_byte;
    logic       byte_valid;
  } res_t;

  // crc-8, polynomial 0x07, one byte
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ 8'h07) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

[hdl/bbhs_if.sv]
// valid/ready channel interfaces for input items and result items

interface bbhs_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic       miso;
  logic [7:0] data;
  logic       last_byte;

  modport source (output valid, kind, miso, data, last_byte, input ready);
  modport sink (input valid, kind, miso, data, last_byte, output ready);
endinterface

interface bbhs_out_if;
  logic       valid;
  logic       ready;
  logic       mosi_level;
  logic [2:0] status;
  logic [7:0] rx_byte;
  logic       byte_valid;
  logic       last;

  modport source (output valid, mosi_level, status, rx_byte, byte_valid, last, input ready);
  modport sink (input valid, mosi_level, status, rx_byte, byte_valid, last, output ready);
endinterface

[hdl/bitbang_link_handshake_master_unit.sv]
// top level of the bit-banged link master with handshake and crc-8 check
// latency: the first result of an item is valid the cycle after its transfer
// flow: each item gives one result, except send byte, which gives eight results;
// the next item transfers as the last result is taken, or whenever the result stage is empty
// reset: state clears to idle with the line low, registers load their defaults
module bitbang_link_handshake_master_unit import bbhs_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  bbhs_in_if.sink                 in_i,
  bbhs_out_if.source              out_o,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ApbAddrWidth-1:0] paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  cfg_t cfg;
  res_t res;
  logic in_ready;
  logic accept;

  assign in_i.ready = in_ready;
  assign accept     = in_i.valid && in_ready;

  // configuration registers
  bbhs_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // link state machine
  bbhs_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .accept_i    (accept),
    .kind_i      (in_i.kind),
    .miso_i      (in_i.miso),
    .data_i      (in_i.data),
    .last_byte_i (in_i.last_byte),
    .res_o       (res)
  );

  // result stage
  bbhs_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .res_i      (res),
    .out_o      (out_o)
  );

endmodule

[hdl/bbhs_cfg.sv]
// apb configuration registers
module bbhs_cfg import bbhs_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ApbAddrWidth-1:0] paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  output cfg_t                    cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ApbAddrWidth-1:2];
  assign cfg_o   = cfg_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.send_ack_window    <= 8'd150;
      cfg_q.ack_run_needed     <= 4'd3;
      cfg_q.send_release_limit <= 6'd20;
      cfg_q.recv_hold_ticks    <= 8'd50;
      cfg_q.recv_release_limit <= 8'd50;
      cfg_q.verify_echo        <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SEND_ACK_WINDOW:    cfg_q.send_ack_window    <= pwdata[7:0];
        REG_ACK_RUN_NEEDED:     cfg_q.ack_run_needed     <= pwdata[3:0];
        REG_SEND_RELEASE_LIMIT: cfg_q.send_release_limit <= pwdata[5:0];
        REG_RECV_HOLD_TICKS:    cfg_q.recv_hold_ticks    <= pwdata[7:0];
        REG_RECV_RELEASE_LIMIT: cfg_q.recv_release_limit <= pwdata[7:0];
        REG_VERIFY_ECHO:        cfg_q.verify_echo        <= pwdata[0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      REG_SEND_ACK_WINDOW:    prdata = {24'd0, cfg_q.send_ack_window};
      REG_ACK_RUN_NEEDED:     prdata = {28'd0, cfg_q.ack_run_needed};
      REG_SEND_RELEASE_LIMIT: prdata = {26'd0, cfg_q.send_release_limit};
      REG_RECV_HOLD_TICKS:    prdata = {24'd0, cfg_q.recv_hold_ticks};
      REG_RECV_RELEASE_LIMIT: prdata = {24'd0, cfg_q.recv_release_limit};
      REG_VERIFY_ECHO:        prdata = {31'd0, cfg_q.verify_echo};
      default:                prdata = 32'd0;
    endcase
  end

endmodule

[hdl/bbhs_core.sv]
// link state machine: handshakes, receive shifter and crc check
module bbhs_core import bbhs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       accept_i,
  input  logic [2:0] kind_i,
  input  logic       miso_i,
  input  logic [7:0] data_i,
  input  logic       last_byte_i,
  output res_t       res_o
);

  // phase codes
  localparam logic [3:0] PH_IDLE      = 4'd0;
  localparam logic [3:0] PH_S_WAKE_HI = 4'd1;
  localparam logic [3:0] PH_S_WAKE_LO = 4'd2;
  localparam logic [3:0] PH_S_ACK     = 4'd3;
  localparam logic [3:0] PH_S_REL     = 4'd4;
  localparam logic [3:0] PH_S_READY   = 4'd5;
  localparam logic [3:0] PH_R_HOLD    = 4'd6;
  localparam logic [3:0] PH_R_REL     = 4'd7;
  localparam logic [3:0] PH_R_DATA    = 4'd8;

  localparam logic [2:0] CrcLastIdx   = 3'(RxFrameBytes - 2);
  localparam logic [2:0] FrameLastIdx = 3'(RxFrameBytes - 1);

  logic [3:0] phase_q, phase_d;
  logic [7:0] tick_q, tick_d;
  logic [4:0] ack_run_q, ack_run_d;
  logic [7:0] rx_shift_q, rx_shift_d;
  logic [2:0] bit_idx_q, bit_idx_d;
  logic [2:0] byte_idx_q, byte_idx_d;
  logic [7:0] crc_q, crc_d;
  logic [7:0] prev_byte_q, prev_byte_d;
  logic       mosi_q, mosi_d;
  logic       match_q, match_d;

  logic [7:0] tick_inc;
  logic [4:0] run_inc;
  logic [7:0] shifted;
  logic       echo_bit;

  assign tick_inc = (tick_q == 8'hFF) ? tick_q : tick_q + 8'd1;
  assign run_inc  = ack_run_q + 5'd1;
  assign shifted  = {rx_shift_q[6:0], miso_i};
  assign echo_bit = cfg_i.verify_echo & prev_byte_q[3'd7 - bit_idx_q];

  // next state and result for one item
  always_comb begin
    phase_d     = phase_q;
    tick_d      = tick_q;
    ack_run_d   = ack_run_q;
    rx_shift_d  = rx_shift_q;
    bit_idx_d   = bit_idx_q;
    byte_idx_d  = byte_idx_q;
    crc_d       = crc_q;
    prev_byte_d = prev_byte_q;
    mosi_d      = mosi_q;
    match_d     = match_q;

    res_o.multi      = 1'b0;
    res_o.data       = data_i;
    res_o.mosi       = 1'b0;
    res_o.status     = ST_REJ;
    res_o.rx_byte    = 8'd0;
    res_o.byte_valid = 1'b0;

    case (kind_i)
      KIND_BEGIN_SEND: begin
        if (phase_q == PH_IDLE) begin
          mosi_d       = 1'b1;
          phase_d      = PH_S_WAKE_HI;
          res_o.status = ST_HS;
        end
      end
      KIND_BEGIN_RECV: begin
        if (phase_q == PH_IDLE) begin
          mosi_d       = 1'b0;
          tick_d       = 8'd0;
          phase_d      = PH_R_HOLD;
          res_o.status = ST_HS;
        end
      end
      KIND_TICK: begin
        res_o.status = ST_HS;
        case (phase_q)
          PH_S_WAKE_HI: begin
            mosi_d  = 1'b0;
            phase_d = PH_S_WAKE_LO;
          end
          PH_S_WAKE_LO: begin
            mosi_d    = 1'b1;
            phase_d   = PH_S_ACK;
            tick_d    = 8'd0;
            ack_run_d = 5'd0;
          end
          PH_S_ACK: begin
            if (miso_i && (run_inc > {1'b0, cfg_i.ack_run_needed})) begin
              mosi_d    = 1'b0;
              ack_run_d = 5'd0;
              tick_d    = 8'd0;
              phase_d   = PH_S_REL;
            end else begin
              ack_run_d = miso_i ? run_inc : 5'd0;
              tick_d    = tick_inc;
              if (tick_inc >= cfg_i.send_ack_window) begin
                mosi_d       = 1'b0;
                phase_d      = PH_IDLE;
                res_o.status = ST_FAIL;
              end
            end
          end
          PH_S_REL: begin
            if (!miso_i) begin
              phase_d      = PH_S_READY;
              res_o.status = ST_READY;
            end else begin
              tick_d = tick_inc;
              if (tick_inc > {2'b00, cfg_i.send_release_limit}) begin
                mosi_d       = 1'b0;
                phase_d      = PH_IDLE;
                res_o.status = ST_FAIL;
              end
            end
          end
          PH_R_HOLD: begin
            if (!miso_i) begin
              mosi_d       = 1'b0;
              phase_d      = PH_IDLE;
              res_o.status = ST_FAIL;
            end else if (tick_inc > cfg_i.recv_hold_ticks) begin
              mosi_d  = 1'b1;
              tick_d  = 8'd0;
              phase_d = PH_R_REL;
            end else begin
              tick_d = tick_inc;
            end
          end
          PH_R_REL: begin
            if (!miso_i) begin
              mosi_d       = 1'b0;
              phase_d      = PH_R_DATA;
              bit_idx_d    = 3'd0;
              byte_idx_d   = 3'd0;
              rx_shift_d   = 8'd0;
              crc_d        = 8'd0;
              prev_byte_d  = 8'd0;
              match_d      = 1'b0;
              res_o.status = ST_READY;
            end else begin
              tick_d = tick_inc;
              if (tick_inc > cfg_i.recv_release_limit) begin
                mosi_d       = 1'b0;
                phase_d      = PH_IDLE;
                res_o.status = ST_FAIL;
              end
            end
          end
          PH_S_READY, PH_R_DATA: res_o.status = ST_READY;
          default:               res_o.status = ST_IDLE;
        endcase
        res_o.mosi = mosi_d;
      end
      KIND_SEND_BYTE: begin
        if (phase_q == PH_S_READY) begin
          res_o.multi  = 1'b1;
          res_o.status = ST_READY;
          if (last_byte_i) begin
            mosi_d  = 1'b0;
            phase_d = PH_IDLE;
          end else begin
            mosi_d = data_i[0];
          end
        end
      end
      KIND_RECV_BIT: begin
        if (phase_q == PH_R_DATA) begin
          mosi_d       = echo_bit;
          rx_shift_d   = shifted;
          bit_idx_d    = bit_idx_q + 3'd1;
          res_o.status = ST_READY;
          // byte complete on the eighth bit
          if (bit_idx_q == 3'd7) begin
            res_o.rx_byte    = shifted;
            res_o.byte_valid = 1'b1;
            prev_byte_d      = shifted;
            if (byte_idx_q < CrcLastIdx) begin
              crc_d = crc8_update(crc_q, shifted);
            end else if (byte_idx_q == CrcLastIdx) begin
              match_d = (crc_q == shifted);
            end
            if (byte_idx_q >= FrameLastIdx) begin
              res_o.status = match_q ? ST_GOOD : ST_BAD;
              byte_idx_d   = 3'd0;
              phase_d      = PH_IDLE;
              mosi_d       = 1'b0;
            end else begin
              byte_idx_d = byte_idx_q + 3'd1;
            end
          end
        end
        res_o.mosi = (phase_q == PH_R_DATA) ? echo_bit : mosi_q;
      end
      KIND_RELEASE: begin
        mosi_d       = 1'b0;
        phase_d      = PH_IDLE;
        res_o.status = ST_IDLE;
      end
      default: ;
    endcase

    // results of kinds other than tick and receive bit report the updated line level
    if (kind_i != KIND_TICK && kind_i != KIND_RECV_BIT) begin
      res_o.mosi = mosi_d;
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      tick_q      <= 8'd0;
      ack_run_q   <= 5'd0;
      rx_shift_q  <= 8'd0;
      bit_idx_q   <= 3'd0;
      byte_idx_q  <= 3'd0;
      crc_q       <= 8'd0;
      prev_byte_q <= 8'd0;
      mosi_q      <= 1'b0;
      match_q     <= 1'b0;
    end else if (accept_i) begin
      phase_q     <= phase_d;
      tick_q      <= tick_d;
      ack_run_q   <= ack_run_d;
      rx_shift_q  <= rx_shift_d;
      bit_idx_q   <= bit_idx_d;
      byte_idx_q  <= byte_idx_d;
      crc_q       <= crc_d;
      prev_byte_q <= prev_byte_d;
      mosi_q      <= mosi_d;
      match_q     <= match_d;
    end
  end

endmodule

[hdl/bbhs_out.sv]
// result register and serializer for the eight bit results of a send byte
module bbhs_out import bbhs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  res_t res_i,
  bbhs_out_if.source out_o
);

  logic       busy_q;
  logic [2:0] beat_q;
  res_t       res_q;
  logic       is_last;
  logic       load;

  assign is_last    = !res_q.multi || (beat_q == 3'd7);
  assign in_ready_o = !busy_q || (out_o.ready && is_last);
  assign load       = in_valid_i && in_ready_o;

  // result fields
  assign out_o.valid      = busy_q;
  assign out_o.mosi_level = res_q.multi ? res_q.data[3'd7 - beat_q] : res_q.mosi;
  assign out_o.status     = res_q.status;
  assign out_o.rx_byte    = res_q.rx_byte;
  assign out_o.byte_valid = res_q.byte_valid;
  assign out_o.last       = is_last;

  // control: occupancy and beat counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      beat_q <= 3'd0;
    end else if (load) begin
      busy_q <= 1'b1;
      beat_q <= 3'd0;
    end else if (busy_q && out_o.ready) begin
      if (is_last) begin
        busy_q <= 1'b0;
      end else begin
        beat_q <= beat_q + 3'd1;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_i;
    end
  end

endmodule

[bench/bitbang_link_handshake_master_unit_tb.sv]
// testbench for the bit-banged link master: handshakes, byte shifting and frame crc check
module bitbang_link_handshake_master_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bbhs_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned TailCycles = 8;
  localparam int unsigned MaxPrints = 100;

  // kinds outside the named set, answered with a reject
  localparam logic [2:0] KIND_SPARE_6 = 3'd6;
  localparam logic [2:0] KIND_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [2:0] kind;
    logic       miso;
    logic [7:0] data;
    logic       last_byte;
  } link_item_t;

  typedef struct packed {
    logic       mosi;
    logic [2:0] status;
    logic [7:0] rx_byte;
    logic       byte_valid;
    logic       last;
  } line_result_t;

  typedef enum logic [3:0] {
    LK_IDLE, LK_WAKE_HI, LK_WAKE_LO, LK_SEND_ACK, LK_SEND_REL, LK_SEND_READY,
    LK_RECV_HOLD, LK_RECV_REL, LK_RECV_DATA
  } link_phase_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [ApbAddrWidth-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bbhs_in_if  in_if ();
  bbhs_out_if out_if ();

  bitbang_link_handshake_master_unit u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if.sink),
    .out_o   (out_if.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk_i = ~clk_i;

  // pending items, expected results and bookkeeping
  link_item_t   link_items_q[$];
  line_result_t line_results_q[$];
  link_item_t   cur_item;
  int unsigned  pushed_cnt = 0;
  int unsigned  accepted_cnt = 0;
  int unsigned  result_cnt = 0;
  int unsigned  fail_cnt = 0;
  int unsigned  cycle_cnt = 0;
  int           phase_items = 0;
  int           span_cap = 40;
  int           send_gap_pct = 0;
  int           sink_stall_pct = 0;

  // register copy at the block's widths
  logic [7:0] cfg_ack_window;
  logic [3:0] cfg_ack_run;
  logic [5:0] cfg_send_rel;
  logic [7:0] cfg_hold;
  logic [7:0] cfg_recv_rel;
  logic       cfg_echo;

  // link state copy
  link_phase_e lk_phase;
  logic [7:0]  tick_cnt;
  logic [7:0]  ack_run;
  logic [7:0]  rx_shift;
  logic [2:0]  bit_idx;
  logic [2:0]  byte_idx;
  logic [7:0]  crc_acc;
  logic [7:0]  prev_byte;
  logic        mosi_q;
  logic        crc_ok;

  function automatic logic [7:0] crc8_next(logic [7:0] acc, logic [7:0] b);
    logic [7:0] r;
    r = acc ^ b;
    repeat (8) r = {r[6:0], 1'b0} ^ (r[7] ? 8'h07 : 8'h00);
    return r;
  endfunction

  function automatic void link_reset();
    cfg_ack_window = 8'd150;
    cfg_ack_run    = 4'd3;
    cfg_send_rel   = 6'd20;
    cfg_hold       = 8'd50;
    cfg_recv_rel   = 8'd50;
    cfg_echo       = 1'b0;
    lk_phase  = LK_IDLE;
    tick_cnt  = 8'h00;
    ack_run   = 8'h00;
    rx_shift  = 8'h00;
    bit_idx   = 3'd0;
    byte_idx  = 3'd0;
    crc_acc   = 8'h00;
    prev_byte = 8'h00;
    mosi_q    = 1'b0;
    crc_ok    = 1'b0;
  endfunction

  function automatic void push_result(logic mosi, logic [2:0] st, logic [7:0] rb,
                                      logic rb_valid, logic last);
    line_result_t r;
    r.mosi       = mosi;
    r.status     = st;
    r.rx_byte    = rb;
    r.byte_valid = rb_valid;
    r.last       = last;
    line_results_q.push_back(r);
  endfunction

  function automatic logic [2:0] link_fail();
    mosi_q   = 1'b0;
    lk_phase = LK_IDLE;
    return ST_FAIL;
  endfunction

  // one millisecond tick with the sampled partner line
  function automatic logic [2:0] link_tick(logic miso);
    case (lk_phase)
      LK_IDLE: return ST_IDLE;
      LK_WAKE_HI: begin
        mosi_q   = 1'b0;
        lk_phase = LK_WAKE_LO;
        return ST_HS;
      end
      LK_WAKE_LO: begin
        mosi_q   = 1'b1;
        lk_phase = LK_SEND_ACK;
        tick_cnt = 8'h00;
        ack_run  = 8'h00;
        return ST_HS;
      end
      LK_SEND_ACK: begin
        if (miso) begin
          if (ack_run != 8'hFF) ack_run = ack_run + 8'd1;
          if (ack_run > {4'h0, cfg_ack_run}) begin
            mosi_q   = 1'b0;
            ack_run  = 8'h00;
            tick_cnt = 8'h00;
            lk_phase = LK_SEND_REL;
            return ST_HS;
          end
        end else begin
          ack_run = 8'h00;
        end
        if (tick_cnt != 8'hFF) tick_cnt = tick_cnt + 8'd1;
        if (tick_cnt >= cfg_ack_window) return link_fail();
        return ST_HS;
      end
      LK_SEND_REL: begin
        if (!miso) begin
          lk_phase = LK_SEND_READY;
          return ST_READY;
        end
        if (tick_cnt != 8'hFF) tick_cnt = tick_cnt + 8'd1;
        if (tick_cnt > {2'b00, cfg_send_rel}) return link_fail();
        return ST_HS;
      end
      LK_RECV_HOLD: begin
        if (!miso) return link_fail();
        if (tick_cnt != 8'hFF) tick_cnt = tick_cnt + 8'd1;
        if (tick_cnt > cfg_hold) begin
          mosi_q   = 1'b1;
          tick_cnt = 8'h00;
          lk_phase = LK_RECV_REL;
        end
        return ST_HS;
      end
      LK_RECV_REL: begin
        if (!miso) begin
          mosi_q    = 1'b0;
          lk_phase  = LK_RECV_DATA;
          bit_idx   = 3'd0;
          byte_idx  = 3'd0;
          rx_shift  = 8'h00;
          crc_acc   = 8'h00;
          prev_byte = 8'h00;
          crc_ok    = 1'b0;
          return ST_READY;
        end
        if (tick_cnt != 8'hFF) tick_cnt = tick_cnt + 8'd1;
        if (tick_cnt > cfg_recv_rel) return link_fail();
        return ST_HS;
      end
      // send ready and receive data just report
      default: return ST_READY;
    endcase
  endfunction

  // expected results of one accepted transfer
  function automatic void link_predict(link_item_t it);
    logic [2:0] st;
    logic       echo;
    logic [7:0] rb;
    logic       rb_valid;
    st = ST_REJ;
    case (it.kind)
      KIND_BEGIN_SEND: if (lk_phase == LK_IDLE) begin
        mosi_q   = 1'b1;
        lk_phase = LK_WAKE_HI;
        st       = ST_HS;
      end
      KIND_BEGIN_RECV: if (lk_phase == LK_IDLE) begin
        mosi_q   = 1'b0;
        tick_cnt = 8'h00;
        lk_phase = LK_RECV_HOLD;
        st       = ST_HS;
      end
      KIND_TICK: st = link_tick(it.miso);
      KIND_SEND_BYTE: if (lk_phase == LK_SEND_READY) begin
        // msb first, one result per bit
        for (int i = 7; i >= 0; i--) begin
          push_result(it.data[i], ST_READY, 8'h00, 1'b0, i == 0);
        end
        mosi_q = it.data[0];
        if (it.last_byte) begin
          mosi_q   = 1'b0;
          lk_phase = LK_IDLE;
        end
        return;
      end
      KIND_RECV_BIT: if (lk_phase == LK_RECV_DATA) begin
        echo     = cfg_echo ? prev_byte[3'd7 - bit_idx] : 1'b0;
        mosi_q   = echo;
        rx_shift = {rx_shift[6:0], it.miso};
        bit_idx  = bit_idx + 3'd1;
        rb       = 8'h00;
        rb_valid = 1'b0;
        st       = ST_READY;
        if (bit_idx == 3'd0) begin
          rb       = rx_shift;
          rb_valid = 1'b1;
          if (byte_idx < RxFrameBytes - 2) crc_acc = crc8_next(crc_acc, rb);
          else if (byte_idx == RxFrameBytes - 2) crc_ok = (crc_acc == rb);
          prev_byte = rb;
          // last byte closes the frame
          if (byte_idx >= RxFrameBytes - 1) begin
            st       = crc_ok ? ST_GOOD : ST_BAD;
            byte_idx = 3'd0;
            lk_phase = LK_IDLE;
            mosi_q   = 1'b0;
          end else begin
            byte_idx = byte_idx + 3'd1;
          end
        end
        push_result(echo, st, rb, rb_valid, 1'b1);
        return;
      end
      KIND_RELEASE: begin
        mosi_q   = 1'b0;
        lk_phase = LK_IDLE;
        st       = ST_IDLE;
      end
      default: ;
    endcase
    push_result(mosi_q, st, 8'h00, 1'b0, 1'b1);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    fail_cnt++;
    if (fail_cnt <= MaxPrints) begin
      $display("mismatch at result %0d: %s got %0d expected %0d", result_cnt, what, got, want);
    end
  endtask

  // input driver: next item after each transfer, random sender gaps
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        link_predict(cur_item);
        accepted_cnt++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (link_items_q.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          cur_item        = link_items_q.pop_front();
          in_if.valid     <= 1'b1;
          in_if.kind      <= cur_item.kind;
          in_if.miso      <= cur_item.miso;
          in_if.data      <= cur_item.data;
          in_if.last_byte <= cur_item.last_byte;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: field checks against the oldest expectation, random stalls
  always @(posedge clk_i) begin
    line_result_t want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (line_results_q.size() == 0) begin
          report_mismatch("result with nothing expected, status", int'(out_if.status), -1);
        end else begin
          want = line_results_q.pop_front();
          if (out_if.mosi_level !== want.mosi)
            report_mismatch("mosi_level", int'(out_if.mosi_level), int'(want.mosi));
          if (out_if.status !== want.status)
            report_mismatch("status", int'(out_if.status), int'(want.status));
          if (out_if.rx_byte !== want.rx_byte)
            report_mismatch("rx_byte", int'(out_if.rx_byte), int'(want.rx_byte));
          if (out_if.byte_valid !== want.byte_valid)
            report_mismatch("byte_valid", int'(out_if.byte_valid), int'(want.byte_valid));
          if (out_if.last !== want.last)
            report_mismatch("last", int'(out_if.last), int'(want.last));
        end
        result_cnt++;
      end
      out_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("bitbang_link_handshake_master_unit_tb NOT OK");
      $finish;
    end
  end

  function automatic logic rand_bit();
    return ($urandom & 32'd1) != 0;
  endfunction

  function automatic logic chance(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // byte with extra weight on the extremes
  function automatic logic [7:0] rand_byte();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  function automatic void push_item(logic [2:0] kind, logic miso, logic [7:0] data,
                                    logic last_byte);
    link_item_t it;
    it.kind      = kind;
    it.miso      = miso;
    it.data      = data;
    it.last_byte = last_byte;
    link_items_q.push_back(it);
    pushed_cnt++;
    phase_items++;
  endfunction

  function automatic void push_tick(logic miso);
    push_item(KIND_TICK, miso, 8'($urandom), rand_bit());
  endfunction

  function automatic void push_release();
    push_item(KIND_RELEASE, rand_bit(), 8'($urandom), rand_bit());
  endfunction

  // send: wake pulse, acknowledge run, release, then bytes
  function automatic void gen_send();
    int mode;
    int need;
    int noise;
    int room;
    int n;
    int nbytes;
    logic abort;
    mode = $urandom_range(0, 9);
    push_item(KIND_BEGIN_SEND, rand_bit(), 8'($urandom), rand_bit());
    push_tick(rand_bit());
    push_tick(rand_bit());
    if (mode == 0) begin
      // partner never answers
      n = (int'(cfg_ack_window) <= span_cap) ? int'(cfg_ack_window) : 3;
      repeat (n) push_tick(1'b0);
      if (n < int'(cfg_ack_window)) push_release();
      return;
    end
    need  = int'(cfg_ack_run) + 1;
    room  = int'(cfg_ack_window) - need;
    noise = $urandom_range(0, 3);
    if (noise > room) noise = (room > 0) ? room : 0;
    for (int i = 0; i < noise; i++) push_tick((i == noise - 1) ? 1'b0 : rand_bit());
    repeat (need) push_tick(1'b1);
    if (mode == 1) begin
      // partner holds the line too long
      n = int'(cfg_send_rel) + 1;
      if (n > span_cap) n = 3;
      repeat (n) push_tick(1'b1);
      if (n <= int'(cfg_send_rel)) push_release();
      return;
    end
    n = $urandom_range(0, (int'(cfg_send_rel) < 3) ? int'(cfg_send_rel) : 3);
    repeat (n) push_tick(1'b1);
    push_tick(1'b0);
    nbytes = $urandom_range(1, 3);
    abort  = chance(15);
    for (int b = 0; b < nbytes; b++) begin
      if (chance(10)) push_item(chance(50) ? KIND_TICK : 3'($urandom_range(0, 7)),
                                rand_bit(), 8'($urandom), rand_bit());
      push_item(KIND_SEND_BYTE, rand_bit(), rand_byte(), (b == nbytes - 1) && !abort);
    end
    if (abort) push_release();
  endfunction

  // receive: hold, release, then a frame msb first
  function automatic void gen_recv();
    logic [7:0] rx_frame [RxFrameBytes];
    logic [7:0] acc;
    int mode;
    int n;
    int stop_at;
    mode = $urandom_range(0, 9);
    push_item(KIND_BEGIN_RECV, rand_bit(), 8'($urandom), rand_bit());
    if (mode == 0 || cfg_hold == 8'hFF) begin
      // hold broken off early; always so when the hold count is at its saturating value
      if (cfg_hold == 8'hFF) n = (span_cap > 255) ? 258 : 5;
      else n = $urandom_range(0, int'(cfg_hold));
      if (n > span_cap) n = span_cap;
      repeat (n) push_tick(1'b1);
      if (chance(50)) push_tick(1'b0);
      else push_release();
      return;
    end
    repeat (int'(cfg_hold) + 1) push_tick(1'b1);
    if (mode == 1) begin
      // partner never lets go
      n = int'(cfg_recv_rel) + 1;
      if (n > span_cap) n = 4;
      repeat (n) push_tick(1'b1);
      if (n <= int'(cfg_recv_rel) || cfg_recv_rel == 8'hFF) push_release();
      return;
    end
    n = $urandom_range(0, (int'(cfg_recv_rel) < 3) ? int'(cfg_recv_rel) : 3);
    repeat (n) push_tick(1'b1);
    push_tick(1'b0);
    // frame with a good check byte most of the time
    acc = 8'h00;
    for (int i = 0; i < RxFrameBytes; i++) begin
      rx_frame[i] = rand_byte();
      if (i < RxFrameBytes - 2) acc = crc8_next(acc, rx_frame[i]);
    end
    if (chance(80)) rx_frame[RxFrameBytes - 2] = acc;
    stop_at = chance(10) ? $urandom_range(0, RxFrameBytes * 8 - 1) : -1;
    for (int j = 0; j < RxFrameBytes * 8; j++) begin
      if (j == stop_at) begin
        push_release();
        return;
      end
      if (chance(5)) push_tick(rand_bit());
      push_item(KIND_RECV_BIT, rx_frame[j / 8][7 - (j % 8)], 8'($urandom), rand_bit());
    end
  endfunction

  // a few arbitrary items, then back to idle
  function automatic void gen_noise();
    repeat ($urandom_range(1, 3)) begin
      push_item(3'($urandom_range(0, 7)), rand_bit(), 8'($urandom), rand_bit());
    end
    push_release();
  endfunction

  task automatic wait_drained();
    while (accepted_cnt != pushed_cnt || line_results_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [2:0] idx, logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_SEND_ACK_WINDOW:    cfg_ack_window = value[7:0];
      REG_ACK_RUN_NEEDED:     cfg_ack_run    = value[3:0];
      REG_SEND_RELEASE_LIMIT: cfg_send_rel   = value[5:0];
      REG_RECV_HOLD_TICKS:    cfg_hold       = value[7:0];
      REG_RECV_RELEASE_LIMIT: cfg_recv_rel   = value[7:0];
      REG_VERIFY_ECHO:        cfg_echo       = value[0];
      default: ;
    endcase
  endtask

  task automatic set_link_cfg(int window, int run, int srel, int hold, int rrel, int echo);
    apb_write(REG_SEND_ACK_WINDOW, 32'(window));
    apb_write(REG_ACK_RUN_NEEDED, 32'(run));
    apb_write(REG_SEND_RELEASE_LIMIT, 32'(srel));
    apb_write(REG_RECV_HOLD_TICKS, 32'(hold));
    apb_write(REG_RECV_RELEASE_LIMIT, 32'(rrel));
    apb_write(REG_VERIFY_ECHO, 32'(echo));
  endtask

  // one stretch of random traffic under the current settings
  task automatic run_traffic(int budget, int gap_pct, int stall_pct);
    int pick;
    send_gap_pct   = gap_pct;
    sink_stall_pct = stall_pct;
    phase_items    = 0;
    gen_send();
    gen_recv();
    while (phase_items < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) gen_send();
      else if (pick < 75) gen_recv();
      else gen_noise();
    end
    wait_drained();
  endtask

  initial begin
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_if.valid     = 1'b0;
    in_if.kind      = KIND_TICK;
    in_if.miso      = 1'b0;
    in_if.data      = 8'h00;
    in_if.last_byte = 1'b0;
    out_if.ready    = 1'b0;
    link_reset();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: rejects, a short send, a failed receive, an aborted send
    set_link_cfg(20, 1, 3, 1, 3, 1);
    push_item(KIND_SPARE_6, 1'b1, 8'h00, 1'b0);
    push_item(KIND_SPARE_7, 1'b0, 8'hFF, 1'b1);
    push_tick(1'b1);
    push_item(KIND_SEND_BYTE, 1'b0, 8'hFF, 1'b1);
    push_item(KIND_RECV_BIT, 1'b1, 8'h00, 1'b0);
    push_release();
    push_item(KIND_BEGIN_SEND, 1'b0, 8'h00, 1'b0);
    push_item(KIND_BEGIN_SEND, 1'b1, 8'hFF, 1'b1);
    push_item(KIND_BEGIN_RECV, 1'b0, 8'h00, 1'b0);
    push_tick(1'b0);
    push_tick(1'b1);
    push_tick(1'b1);
    push_tick(1'b1);
    push_tick(1'b1);
    push_tick(1'b0);
    push_item(KIND_RECV_BIT, 1'b0, 8'h00, 1'b0);
    push_tick(1'b1);
    push_item(KIND_SEND_BYTE, 1'b1, 8'h00, 1'b0);
    push_item(KIND_SEND_BYTE, 1'b0, 8'hFF, 1'b1);
    push_item(KIND_BEGIN_RECV, 1'b1, 8'h00, 1'b0);
    push_tick(1'b0);
    push_item(KIND_BEGIN_SEND, 1'b0, 8'h00, 1'b0);
    push_tick(1'b1);
    push_release();
    wait_drained();

    // reset values, no idling
    set_link_cfg(150, 3, 20, 50, 50, 0);
    run_traffic(40, 0, 0);

    // minima, sender mostly idle
    set_link_cfg(1, 0, 0, 0, 0, 0);
    run_traffic(40, 81, 0);

    // moderate random settings, receiver mostly stalled
    set_link_cfg($urandom_range(2, 60), $urandom_range(0, 15), $urandom_range(0, 63),
                 $urandom_range(0, 20), $urandom_range(0, 20), $urandom_range(0, 1));
    run_traffic(40, 0, 81);

    // maxima, both sides idling
    set_link_cfg(255, 15, 63, 255, 255, 1);
    run_traffic(40, 24, 24);

    if (fail_cnt == 0) begin
      $display("bitbang_link_handshake_master_unit_tb OK");
    end else begin
      $display("bitbang_link_handshake_master_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
